[rtl/core/byte_histogram_l1_distance_top_defines.svh]
// Assertion macros shared by the byte histogram checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef BYTE_HISTOGRAM_L1_DISTANCE_TOP_DEFINES_SVH
`define BYTE_HISTOGRAM_L1_DISTANCE_TOP_DEFINES_SVH

// Same-cycle implication.
`define BHLD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bhld check failed");

// Next-cycle implication.
`define BHLD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bhld check failed");

`endif

[rtl/core/bhld_pkg.sv]
// Package for the byte histogram L1 distance block.
// Field widths, operation codes and the sequencer state type; no dependencies.
`default_nettype none

package bhld_pkg;

	localparam int FUNC_W = 3;
	localparam int SYM_W  = 8;
	localparam int AMT_W  = 16;
	localparam int DIST_W = 24;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef logic [FUNC_W-1:0] func_t;

	localparam func_t FN_BUMP_P    = 3'd0;
	localparam func_t FN_BUMP_S    = 3'd1;
	localparam func_t FN_MERGE_ADD = 3'd2;
	localparam func_t FN_MERGE_SUB = 3'd3;
	localparam func_t FN_DIST      = 3'd4;
	localparam func_t FN_CLEAR     = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BUMP,
		ST_CLEAR,
		ST_SWEEP,
		ST_DRAIN,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

[rtl/core/byte_histogram_l1_distance_top.sv]
// Bump: reads the bin at accept and writes it back in the next cycle; no item is taken meanwhile.
// Merge add/sub: one bin a cycle, each result written back into the primary store.
// Distance: sweeps both stores, sums the absolute bin differences (saturating) and loads the
// result register once it is free; no item is taken until then. Clear: one bin of each store zeroed a cycle.
// Reset (arst_n low) starts the same clearing pass; no item is taken meanwhile.
// Depends on bhld_pkg.
`default_nettype none

module byte_histogram_l1_distance_top #(
	parameter int BINS        = 256,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  bhld_pkg::func_t                  func,
	input  logic [bhld_pkg::SYM_W-1:0]       symbol,
	input  logic signed [bhld_pkg::AMT_W-1:0] amount,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic [bhld_pkg::DIST_W-1:0]      distance
);
	import bhld_pkg::*;

	localparam int AW  = $clog2(BINS);
	localparam int EW  = (AW > SYM_W) ? AW : SYM_W;
	localparam int CW  = COUNT_WIDTH;
	localparam int ADW = CW + 1;
	localparam int SW  = ((DIST_W > ADW) ? DIST_W : ADW) + 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(BINS - 1);

	logic [CW-1:0] prim_mem [BINS];
	logic [CW-1:0] sec_mem [BINS];

	state_t state_q, state_d;
	func_t  op_q;
	logic [AW-1:0] idx_q;
	logic          last_idx;
	logic          accept;

	logic [EW:0]   sym_ext;
	logic          sym_hit;
	logic [AW-1:0] sym_addr;
	logic [CW+AMT_W-1:0] amt_wide;

	logic [AW-1:0] bump_addr_q;
	logic          bump_hit_q;
	logic [CW-1:0] amt_q;

	logic [AW-1:0] rd_addr;
	logic [CW-1:0] p_rd_s1, s_rd_s1;
	logic          v_s1;
	logic [AW-1:0] addr_s1;
	logic [CW:0]   diff_s1;
	logic [ADW-1:0] absd_s1;

	logic [ADW-1:0] absd_s2;
	logic           v_s2;

	logic [DIST_W-1:0] acc_q;
	logic [SW-1:0]     acc_sum;
	logic [DIST_W-1:0] acc_next;

	logic              res_valid_q;
	logic [DIST_W-1:0] dist_q;
	logic              load_res;

	logic          we_p, we_s;
	logic [AW-1:0] wa_p, wa_s;
	logic [CW-1:0] wd_p, wd_s;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign last_idx  = (idx_q == LAST_IDX);

	assign sym_ext  = (EW + 1)'(symbol);
	assign sym_hit  = (sym_ext < (EW + 1)'(BINS));
	assign sym_addr = sym_ext[AW-1:0];
	assign amt_wide = (CW + AMT_W)'(amount);

	// bump reads at the accept edge, sweeps read at the running index
	assign rd_addr = (state_q == ST_IDLE) ? sym_addr : idx_q;

	assign diff_s1 = {p_rd_s1[CW-1], p_rd_s1} - {s_rd_s1[CW-1], s_rd_s1};
	assign absd_s1 = diff_s1[CW] ? ADW'(~diff_s1 + 1'b1) : ADW'(diff_s1);

	assign acc_sum  = SW'(acc_q) + SW'(absd_s2);
	assign acc_next = (acc_sum > SW'(DIST_MAX)) ? DIST_MAX : acc_sum[DIST_W-1:0];

	always_comb begin
		state_d  = state_q;
		load_res = 1'b0;
		we_p     = 1'b0;
		we_s     = 1'b0;
		wa_p     = idx_q;
		wa_s     = idx_q;
		wd_p     = '0;
		wd_s     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (func)
						FN_BUMP_P, FN_BUMP_S:               state_d = ST_BUMP;
						FN_MERGE_ADD, FN_MERGE_SUB, FN_DIST: state_d = ST_SWEEP;
						FN_CLEAR:                           state_d = ST_CLEAR;
						default:                            state_d = ST_IDLE;
					endcase
				end
			end
			ST_BUMP: begin
				state_d = ST_IDLE;
				if (bump_hit_q) begin
					if (op_q == FN_BUMP_P) begin
						we_p = 1'b1;
						wa_p = bump_addr_q;
						wd_p = p_rd_s1 + amt_q;
					end else begin
						we_s = 1'b1;
						wa_s = bump_addr_q;
						wd_s = s_rd_s1 + amt_q;
					end
				end
			end
			ST_CLEAR: begin
				we_p = 1'b1;
				we_s = 1'b1;
				if (last_idx) begin
					state_d = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				if (last_idx) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = (op_q == FN_DIST) ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (!res_valid_q || res_ready) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		// merge write-back happens in the cycle after the read
		if (v_s1 && (op_q == FN_MERGE_ADD || op_q == FN_MERGE_SUB)) begin
			we_p = 1'b1;
			wa_p = addr_s1;
			wd_p = (op_q == FN_MERGE_ADD) ? (p_rd_s1 + s_rd_s1) : (p_rd_s1 - s_rd_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			op_q        <= FN_CLEAR;
			idx_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q <= func;
			end
			if (state_q == ST_CLEAR || state_q == ST_SWEEP) begin
				idx_q <= last_idx ? '0 : idx_q + 1'b1;
			end
			v_s1 <= (state_q == ST_SWEEP);
			v_s2 <= v_s1 && (op_q == FN_DIST);
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bump_addr_q <= sym_addr;
			bump_hit_q  <= sym_hit;
			amt_q       <= amt_wide[CW-1:0];
			acc_q       <= '0;
		end else if (v_s2) begin
			acc_q <= acc_next;
		end
		addr_s1 <= idx_q;
		absd_s2 <= absd_s1;
		if (load_res) begin
			dist_q <= acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we_p) begin
			prim_mem[wa_p] <= wd_p;
		end
		if (we_s) begin
			sec_mem[wa_s] <= wd_s;
		end
		p_rd_s1 <= prim_mem[rd_addr];
		s_rd_s1 <= sec_mem[rd_addr];
	end

	assign res_valid = res_valid_q;
	assign distance  = dist_q;

endmodule

`default_nettype wire

[rtl/core/bhld_checker.sv]
// Port-level checks for byte_histogram_l1_distance_top, bound to it below.
// Depends on bhld_pkg and byte_histogram_l1_distance_top_defines.svh.
`default_nettype none

`include "byte_histogram_l1_distance_top_defines.svh"

module bhld_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input bhld_pkg::func_t                   func,
	input logic [bhld_pkg::SYM_W-1:0]        symbol,
	input logic signed [bhld_pkg::AMT_W-1:0] amount,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic [bhld_pkg::DIST_W-1:0]       distance
);
	import bhld_pkg::*;

	`BHLD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
	`BHLD_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(distance))
	// any real operation drops ready in the cycle after it is accepted
	`BHLD_ASSERT_NEXT(a_busy_after_op, req_valid && req_ready && func <= FN_CLEAR, !req_ready)
	// a result beat only appears out of the busy distance sequence
	`BHLD_ASSERT_SAME(a_res_after_work, $rose(res_valid), !$past(req_ready))

endmodule

bind byte_histogram_l1_distance_top bhld_checker u_bhld_checker (.*);

`default_nettype wire

[tb/tb_byte_histogram_l1_distance_top.sv]
// Self-checking testbench for byte_histogram_l1_distance_top: bumps, merges, clears, L1 distance.
// Keeps its own copy of both histograms and checks every distance beat in order.
// Depends on bhld_pkg and the top-level RTL.
`default_nettype none

module tb_byte_histogram_l1_distance_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bhld_pkg::*;

	localparam int     NUM_BINS   = 256;
	localparam int     RAND_ITEMS = 320;
	localparam int     TAIL_CYCS  = 300;
	localparam func_t  FN_RSVD_6  = 3'd6;
	localparam func_t  FN_RSVD_7  = 3'd7;

	typedef struct packed {
		func_t              f;
		logic [SYM_W-1:0]   sym;
		logic [AMT_W-1:0]   amt;
		logic               known;
		logic [DIST_W-1:0]  dist_val;
	} op_row_t;

	// Opening sequence; known distances are worked out by hand from the bin values.
	localparam int N_ROWS = 16;
	localparam op_row_t OP_TABLE [N_ROWS] = '{
		'{FN_DIST,      8'h00, 16'h0000, 1'b1, 24'd0},
		'{FN_BUMP_P,    8'h00, 16'h7FFF, 1'b0, 24'd0},
		'{FN_BUMP_S,    8'hFF, 16'h8000, 1'b0, 24'd0},
		'{FN_DIST,      8'h00, 16'h0000, 1'b1, 24'd65535},
		'{FN_BUMP_P,    8'h00, 16'h0001, 1'b0, 24'd0},   // bin wraps to most negative
		'{FN_DIST,      8'hFF, 16'hFFFF, 1'b1, 24'd65536},
		'{FN_RSVD_6,    8'h00, 16'h0005, 1'b0, 24'd0},
		'{FN_RSVD_7,    8'h01, 16'hFFFF, 1'b0, 24'd0},
		'{FN_DIST,      8'h00, 16'h0000, 1'b1, 24'd65536},
		'{FN_BUMP_S,    8'h00, 16'hFFFF, 1'b0, 24'd0},
		'{FN_DIST,      8'h00, 16'h0000, 1'b1, 24'd65535},
		'{FN_MERGE_ADD, 8'h55, 16'h1234, 1'b0, 24'd0},
		'{FN_DIST,      8'h00, 16'h0000, 1'b1, 24'd32768},
		'{FN_MERGE_SUB, 8'hAA, 16'hABCD, 1'b0, 24'd0},
		'{FN_CLEAR,     8'hFF, 16'h7FFF, 1'b0, 24'd0},
		'{FN_DIST,      8'h00, 16'h0000, 1'b1, 24'd0}
	};

	logic                     clk;
	logic                     arst_n;
	logic                     req_valid;
	logic                     req_ready;
	func_t                    func;
	logic [SYM_W-1:0]         symbol;
	logic signed [AMT_W-1:0]  amount;
	logic                     res_valid;
	logic                     res_ready;
	logic [DIST_W-1:0]        distance;

	logic [15:0]        prim_hist [NUM_BINS];
	logic [15:0]        sec_hist  [NUM_BINS];
	logic [DIST_W-1:0]  dist_expect_q [$];
	int                 err_count;
	int                 items_sent;
	int                 send_idle_pct;
	int                 recv_idle_pct;

	byte_histogram_l1_distance_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.func      (func),
		.symbol    (symbol),
		.amount    (amount),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.distance  (distance)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [DIST_W-1:0] got,
			input logic [DIST_W-1:0] want);
		err_count++;
		$display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $time);
	endtask

	function automatic logic [DIST_W-1:0] l1_distance();
		longint sum;
		int     d;
		sum = 0;
		for (int k = 0; k < NUM_BINS; k++) begin
			d = int'($signed(prim_hist[k])) - int'($signed(sec_hist[k]));
			sum += (d < 0) ? -d : d;
		end
		if (sum > longint'(DIST_MAX))
			sum = longint'(DIST_MAX);
		return sum[DIST_W-1:0];
	endfunction

	function automatic void clear_hists();
		for (int k = 0; k < NUM_BINS; k++) begin
			prim_hist[k] = '0;
			sec_hist[k]  = '0;
		end
	endfunction

	// Update the histogram copy for one accepted beat; queue the distance if one is due.
	function automatic void apply_op(func_t f, logic [SYM_W-1:0] s, logic [AMT_W-1:0] a,
			logic known, logic [DIST_W-1:0] known_dist);
		case (f)
			FN_BUMP_P:    prim_hist[s] = prim_hist[s] + a;
			FN_BUMP_S:    sec_hist[s]  = sec_hist[s] + a;
			FN_MERGE_ADD: for (int k = 0; k < NUM_BINS; k++) prim_hist[k] = prim_hist[k] + sec_hist[k];
			FN_MERGE_SUB: for (int k = 0; k < NUM_BINS; k++) prim_hist[k] = prim_hist[k] - sec_hist[k];
			FN_DIST:      dist_expect_q.push_back(known ? known_dist : l1_distance());
			FN_CLEAR:     clear_hists();
			default:      ;
		endcase
	endfunction

	task automatic send_beat(input func_t f, input logic [SYM_W-1:0] s, input logic [AMT_W-1:0] a,
			input logic known = 1'b0, input logic [DIST_W-1:0] known_dist = '0);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		func      <= f;
		symbol    <= s;
		amount    <= a;
		do @(posedge clk); while (!req_ready);
		apply_op(f, s, a, known, known_dist);
		items_sent++;
	endtask

	task automatic wait_results_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (dist_expect_q.size() != 0);
	endtask

	function automatic logic [AMT_W-1:0] rand_amount();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40)
			return AMT_W'($urandom);
		else if (pick < 85)
			return AMT_W'($urandom_range(16) - 8);
		case ($urandom_range(3))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return 16'hFFFF;
			default: return 16'h0001;
		endcase
	endfunction

	function automatic logic [SYM_W-1:0] rand_symbol();
		int pick;
		pick = $urandom_range(99);
		if (pick < 50)
			return SYM_W'($urandom_range(255));
		else if (pick < 80)
			return SYM_W'($urandom_range(3));
		return SYM_W'($urandom_range(255, 252));
	endfunction

	function automatic func_t rand_bump();
		return $urandom_range(1) ? FN_BUMP_P : FN_BUMP_S;
	endfunction

	function automatic func_t rand_merge();
		return $urandom_range(1) ? FN_MERGE_ADD : FN_MERGE_SUB;
	endfunction

	// Mostly bump bursts closed by a distance query, plus merges, clears and stray beats.
	task automatic send_sequence();
		int kind;
		int n;
		kind = $urandom_range(99);
		if (kind < 65) begin
			n = $urandom_range(12, 1);
			repeat (n) send_beat(rand_bump(), rand_symbol(), rand_amount());
			if ($urandom_range(3) == 0)
				send_beat(rand_merge(), SYM_W'($urandom), AMT_W'($urandom));
			send_beat(FN_DIST, SYM_W'($urandom), AMT_W'($urandom));
		end else if (kind < 75) begin
			send_beat(rand_merge(), SYM_W'($urandom), AMT_W'($urandom));
			send_beat(FN_DIST, SYM_W'($urandom), AMT_W'($urandom));
		end else if (kind < 80) begin
			send_beat(FN_CLEAR, SYM_W'($urandom), AMT_W'($urandom));
			send_beat(rand_bump(), rand_symbol(), rand_amount());
			send_beat(FN_DIST, SYM_W'($urandom), AMT_W'($urandom));
		end else begin
			send_beat(func_t'($urandom_range(7)), rand_symbol(), rand_amount());
		end
	endtask

	always @(posedge clk) begin : res_check
		logic [DIST_W-1:0] want;
		if (arst_n && res_valid && res_ready) begin
			if (dist_expect_q.size() == 0) begin
				report_mismatch("distance beat with none expected", distance, '0);
			end else begin
				want = dist_expect_q.pop_front();
				if (distance !== want)
					report_mismatch("distance", distance, want);
			end
		end
		res_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		res_ready     = 1'b0;
		func          = FN_BUMP_P;
		symbol        = '0;
		amount        = '0;
		err_count     = 0;
		items_sent    = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		clear_hists();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 18;
		recv_idle_pct = 47;
		foreach (OP_TABLE[i])
			send_beat(OP_TABLE[i].f, OP_TABLE[i].sym, OP_TABLE[i].amt,
				OP_TABLE[i].known, OP_TABLE[i].dist_val);

		// Push every bin to opposite extremes for the largest possible distance.
		for (int k = 0; k < NUM_BINS; k++) begin
			send_beat(FN_BUMP_P, SYM_W'(k), 16'h7FFF);
			send_beat(FN_BUMP_S, SYM_W'(k), 16'h8000);
		end
		send_beat(FN_DIST, 8'h00, 16'h0000, 1'b1, 24'd16776960);
		send_beat(FN_MERGE_SUB, 8'h00, 16'h0000);
		send_beat(FN_DIST, 8'h00, 16'h0000);
		send_beat(FN_CLEAR, 8'h00, 16'h0000);

		items_sent = 0;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 47 : 0;
			recv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 18 : 0;
			while (items_sent < (ph + 1) * RAND_ITEMS / 3)
				send_sequence();
			wait_results_drained();
		end

		repeat (TAIL_CYCS) @(posedge clk);
		if (err_count == 0 && dist_expect_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
